// ----- design/encoder_position_speed_tracker_unit_assert.svh -----
// assertion macros for the encoder position and speed tracker
`ifndef ENCODER_POSITION_SPEED_TRACKER_UNIT_ASSERT_SVH
`define ENCODER_POSITION_SPEED_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define EPST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define EPST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/epst_pkg.sv -----
// shared types, constants and helpers of the encoder position and speed tracker
`timescale 1ns / 1ps
package epst_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int CPT_LOG2   = 12;
    localparam int ANGLE_W    = 16;
    localparam int ADV_W      = CPT_LOG2 + ANGLE_W;
    localparam int POS_W      = 48;
    localparam int TICK_W     = 48;
    localparam int SPD_W      = 32;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 48;
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_AW      = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH   = 2;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TICKS  = 2'd2;

    localparam logic signed [16:0]      HALF_SPAN = 17'sd32767;
    localparam logic signed [POS_W:0]   RAW_SPAN  = 49'sh1_0000;
    localparam logic signed [POS_W-1:0] POS_MIN   = 48'sh8000_0000_0000;
    localparam logic signed [POS_W-1:0] BASE_MAX  = 48'sh7FFF_FFFF_0000;

    typedef struct packed {
        logic [15:0]        raw_position;
        logic [TICK_W-1:0]  capture_tick;
        logic [TICK_W-1:0]  now_tick;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] multi_turn_position;
        logic [ANGLE_W-1:0]      mech_angle;
        logic [ANGLE_W-1:0]      elec_angle;
        logic signed [SPD_W-1:0] speed;
        logic signed [SPD_W-1:0] acceleration;
    } out_item_t;

    typedef struct packed {
        logic [15:0] angle_offset;
        logic [5:0]  pole_pairs;
        logic [31:0] stale_ticks;
    } cfg_t;

    typedef struct packed {
        in_item_t item;
        logic     changed;
        logic     wrap_dn;
        logic     wrap_up;
    } front_item_t;

    function automatic logic [RING_AW-1:0] next_idx(input logic [RING_AW-1:0] i);
        logic [RING_AW-1:0] r;
        if (i == RING_AW'(RING_DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

    function automatic logic signed [SPD_W-1:0] sat32(input logic [DIV_NW-1:0] m,
                                                      input logic neg);
        logic signed [SPD_W-1:0] r;
        if (neg) begin
            if (m >= 64'h8000_0000)
                r = 32'sh8000_0000;
            else
                r = SPD_W'(~m[SPD_W-1:0] + 1'b1);
        end
        else begin
            if (m > 64'h7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else
                r = m[SPD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/epst_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module epst_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [epst_pkg::DIV_NW-1:0] dividend,
    input  logic [epst_pkg::DIV_DW-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [epst_pkg::DIV_NW-1:0] quotient
);
    import epst_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dsr_reg, dsr_next;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;

    // one shift and trial subtract
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NW-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = CNT_W'(DIV_NW);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            rem_next = ge ? DIV_DW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DIV_DW-1:0];
            if (cnt_reg == CNT_W'(1))
                done_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = cnt_reg != '0;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- design/epst_front.sv -----
// input queue that classifies each reading against the previous one
`timescale 1ns / 1ps
module epst_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  epst_pkg::in_item_t    in_item,
    input  logic                  deq,
    output logic                  q_empty,
    output epst_pkg::front_item_t q_item
);
    import epst_pkg::*;

    front_item_t      fq_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FQ_AW:0]   cnt_reg;
    logic [15:0]      last_raw_reg;
    logic signed [16:0] diff;
    front_item_t      cls;
    logic             acc;

    // classify against the last accepted reading
    always_comb
    begin
        diff        = $signed({1'b0, in_item.raw_position}) - $signed({1'b0, last_raw_reg});
        cls.item    = in_item;
        cls.changed = in_item.raw_position != last_raw_reg;
        cls.wrap_dn = diff > HALF_SPAN;
        cls.wrap_up = diff < -HALF_SPAN;
    end

    assign full    = cnt_reg == (FQ_AW+1)'(FQ_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign acc     = push && !full;
    assign q_item  = fq_mem[rd_ptr_reg];

    // queue pointers and last reading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            last_raw_reg <= '0;
        end
        else begin
            if (acc) begin
                wr_ptr_reg   <= wr_ptr_reg + 1'b1;
                last_raw_reg <= in_item.raw_position;
            end
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (acc && !deq)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!acc && deq)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (acc)
            fq_mem[wr_ptr_reg] <= cls;
    end
endmodule

// ----- design/epst_back.sv -----
// sequencer: unwrap, ring update, window scan, speed and angle
`timescale 1ns / 1ps
`include "encoder_position_speed_tracker_unit_assert.svh"
module epst_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  epst_pkg::front_item_t q_item,
    output logic                  deq,
    input  epst_pkg::cfg_t        cfg,
    input  logic                  out_full,
    output logic                  out_push,
    output epst_pkg::out_item_t   out_data
);
    import epst_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UNWRAP  = 4'd1;
    localparam logic [3:0] S_POS     = 4'd2;
    localparam logic [3:0] S_WRITE   = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_DIFF    = 4'd6;
    localparam logic [3:0] S_DIVSPD  = 4'd7;
    localparam logic [3:0] S_WAITSPD = 4'd8;
    localparam logic [3:0] S_DIVACC  = 4'd9;
    localparam logic [3:0] S_WAITACC = 4'd10;
    localparam logic [3:0] S_RDHEAD  = 4'd11;
    localparam logic [3:0] S_HEADCHK = 4'd12;
    localparam logic [3:0] S_ELEC    = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    logic [3:0]               state_reg;
    front_item_t              item_reg;
    logic signed [POS_W-1:0]  base_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic [RING_AW-1:0]       head_reg, first_reg;
    logic [ANGLE_W-1:0]       mech_reg;
    logic signed [SPD_W-1:0]  speed_reg, accel_reg, sfirst_reg;
    logic [TICK_W-1:0]        t_head_reg;
    logic signed [POS_W:0]    dp_reg, dt_reg;
    logic                     neg_reg;
    logic [ADV_W-1:0]         prod_reg;

    // ring storage
    logic [POS_W+TICK_W-1:0]  mem_pt  [RING_DEPTH];
    logic [SPD_W-1:0]         mem_spd [RING_DEPTH];
    logic [RING_DEPTH-1:0]    valid_reg;
    logic [POS_W+TICK_W-1:0]  rd_pt_reg;
    logic [SPD_W-1:0]         rd_spd_reg;
    logic                     rd_valid_reg;
    logic [RING_AW-1:0]       rd_addr;
    logic                     pt_we, spd_we;
    logic [SPD_W-1:0]         spd_wdata;
    logic signed [POS_W-1:0]  rd_pos;
    logic [TICK_W-1:0]        rd_time;
    logic signed [SPD_W-1:0]  rd_spd;

    // divider
    logic                     div_start, div_busy, div_done;
    logic [DIV_NW-1:0]        div_dividend, div_quo;
    logic [DIV_DW-1:0]        div_divisor;

    // misc combinational values
    logic signed [POS_W:0]    base_ext, base_dn, base_up;
    logic signed [POS_W-1:0]  base_unwrap;
    logic signed [POS_W:0]    age;
    logic                     rd_stale;
    logic [POS_W:0]           dp_mag, dt_mag;
    logic signed [SPD_W:0]    dv;
    logic [SPD_W:0]           dv_mag;
    logic signed [SPD_W-1:0]  sat_q;
    logic [TICK_W-1:0]        e_age;
    logic [ANGLE_W-1:0]       e_sum;
    logic [ANGLE_W+5:0]       e_prod;
    logic [ANGLE_W-1:0]       mech_new;

    assign rd_addr   = (state_reg == S_RDHEAD) ? head_reg : first_reg;
    assign rd_pos    = rd_valid_reg ? rd_pt_reg[POS_W+TICK_W-1:TICK_W] : '0;
    assign rd_time   = rd_valid_reg ? rd_pt_reg[TICK_W-1:0] : '0;
    assign rd_spd    = rd_valid_reg ? rd_spd_reg : '0;

    // saturating turn base step
    always_comb
    begin
        base_ext = {base_reg[POS_W-1], base_reg};
        base_dn  = base_ext - RAW_SPAN;
        base_up  = base_ext + RAW_SPAN;
        if (item_reg.wrap_dn)
            base_unwrap = (base_dn < $signed({POS_MIN[POS_W-1], POS_MIN})) ?
                          POS_MIN : base_dn[POS_W-1:0];
        else if (item_reg.wrap_up)
            base_unwrap = (base_up > $signed({1'b0, BASE_MAX})) ?
                          BASE_MAX : base_up[POS_W-1:0];
        else
            base_unwrap = base_reg;
    end

    // staleness of the entry just read
    assign age      = $signed({1'b0, item_reg.item.now_tick}) - $signed({1'b0, rd_time});
    assign rd_stale = age > $signed({17'b0, cfg.stale_ticks});

    // magnitudes and divider operands
    always_comb
    begin
        dp_mag = dp_reg[POS_W] ? (POS_W+1)'(-dp_reg) : dp_reg;
        dt_mag = dt_reg[POS_W] ? (POS_W+1)'(-dt_reg) : dt_reg;
        dv     = $signed({speed_reg[SPD_W-1], speed_reg})
                 - $signed({sfirst_reg[SPD_W-1], sfirst_reg});
        dv_mag = dv[SPD_W] ? (SPD_W+1)'(-dv) : dv;
        div_divisor = dt_mag[DIV_DW-1:0];
        if (state_reg == S_DIVACC)
            div_dividend = DIV_NW'(dv_mag);
        else
            div_dividend = {dp_mag[DIV_NW-17:0], 16'b0};
        sat_q = sat32(div_quo, neg_reg);
    end

    // mechanical angle from the new position
    assign mech_new = (ANGLE_W'(pos_reg[CPT_LOG2-1:0]) << (ANGLE_W - CPT_LOG2))
                      - cfg.angle_offset;

    // electrical angle
    always_comb
    begin
        e_age  = item_reg.item.now_tick - t_head_reg;
        e_sum  = mech_reg + prod_reg[ADV_W-1:CPT_LOG2];
        e_prod = e_sum * cfg.pole_pairs;
    end

    // strobes
    always_comb
    begin
        deq       = (state_reg == S_IDLE) && !q_empty && !out_full;
        pt_we     = state_reg == S_WRITE;
        div_start = 1'b0;
        spd_we    = 1'b0;
        spd_wdata = '0;
        out_push  = state_reg == S_OUT;
        case (state_reg)
            S_SCAN:
            begin
                spd_we = first_reg == head_reg;
            end
            S_DIVSPD:
            begin
                if (dt_reg == '0 || dp_reg == '0)
                    spd_we = 1'b1;
                else
                    div_start = 1'b1;
            end
            S_WAITSPD:
            begin
                spd_we    = div_done;
                spd_wdata = sat_q;
            end
            S_DIVACC:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                spd_we = 1'b0;
            end
        endcase
    end

    assign out_data.multi_turn_position = pos_reg;
    assign out_data.mech_angle          = mech_reg;
    assign out_data.elec_angle          = e_prod[ANGLE_W-1:0];
    assign out_data.speed               = speed_reg;
    assign out_data.acceleration        = accel_reg;

    // sequencer and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            head_reg  <= '0;
            first_reg <= '0;
            mech_reg  <= '0;
            speed_reg <= '0;
            accel_reg <= '0;
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (pt_we)
                valid_reg[head_reg] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (deq)
                        state_reg <= q_item.changed ? S_UNWRAP : S_RDHEAD;
                end
                S_UNWRAP:
                begin
                    base_reg  <= base_unwrap;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    head_reg  <= next_idx(head_reg);
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    mech_reg  <= mech_new;
                    first_reg <= next_idx(head_reg);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (first_reg == head_reg) begin
                        speed_reg <= '0;
                        accel_reg <= '0;
                        state_reg <= S_ELEC;
                    end
                    else
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (rd_stale) begin
                        first_reg <= next_idx(first_reg);
                        state_reg <= S_SCAN;
                    end
                    else
                        state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= S_DIVSPD;
                end
                S_DIVSPD:
                begin
                    if (dt_reg == '0 || dp_reg == '0) begin
                        speed_reg <= '0;
                        accel_reg <= '0;
                        state_reg <= S_ELEC;
                    end
                    else
                        state_reg <= S_WAITSPD;
                end
                S_WAITSPD:
                begin
                    if (div_done) begin
                        speed_reg <= sat_q;
                        state_reg <= S_DIVACC;
                    end
                end
                S_DIVACC:
                begin
                    state_reg <= S_WAITACC;
                end
                S_WAITACC:
                begin
                    if (div_done) begin
                        accel_reg <= sat_q;
                        state_reg <= S_ELEC;
                    end
                end
                S_RDHEAD:
                begin
                    state_reg <= S_HEADCHK;
                end
                S_HEADCHK:
                begin
                    if (rd_stale) begin
                        speed_reg <= '0;
                        accel_reg <= '0;
                    end
                    state_reg <= S_ELEC;
                end
                S_ELEC:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item payload and working values
    always_ff @(posedge clk)
    begin
        if (deq)
            item_reg <= q_item;
        if (state_reg == S_POS || state_reg == S_RDHEAD)
            pos_reg <= base_reg + $signed({32'b0, item_reg.item.raw_position});
        if (state_reg == S_WRITE)
            t_head_reg <= item_reg.item.capture_tick;
        if (state_reg == S_HEADCHK)
            t_head_reg <= rd_time;
        if (state_reg == S_DIFF) begin
            dp_reg     <= $signed({pos_reg[POS_W-1], pos_reg}) - $signed({rd_pos[POS_W-1], rd_pos});
            dt_reg     <= $signed({1'b0, item_reg.item.capture_tick}) - $signed({1'b0, rd_time});
            sfirst_reg <= rd_spd;
        end
        if (state_reg == S_DIVSPD)
            neg_reg <= dp_reg[POS_W] ^ dt_reg[POS_W];
        if (state_reg == S_DIVACC)
            neg_reg <= dv[SPD_W] ^ dt_reg[POS_W];
        if (state_reg == S_ELEC)
            prod_reg <= ADV_W'(speed_reg[ADV_W-1:0] * e_age[ADV_W-1:0]);
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (pt_we)
            mem_pt[head_reg] <= {pos_reg, item_reg.item.capture_tick};
        if (spd_we)
            mem_spd[head_reg] <= spd_wdata;
        rd_pt_reg  <= mem_pt[rd_addr];
        rd_spd_reg <= mem_spd[rd_addr];
    end

    epst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // checks
    `EPST_ASSERT_IMPL(a_div_idle, div_start, !div_busy, "divider started while busy")
    `EPST_ASSERT_IMPL(a_push_room, out_push, !out_full, "result pushed into full queue")
    `EPST_ASSERT_NEXT(a_head_hold, state_reg == S_RDHEAD, $stable(head_reg), "head moved on unchanged reading")
    `EPST_ASSERT_IMPL(a_scan_bound, state_reg == S_CHECK, first_reg != head_reg, "window scan reached the head")
endmodule

// ----- design/encoder_position_speed_tracker_unit.sv -----
// top level: configuration registers, front queue, sequencer and result queue
// flow: an unchanged reading only rereads the head entry; a changed one is unwrapped, written
// to the ring and scanned past each stale entry, then divided twice unless nothing usable moved
// throughput: one item at a time; the sequencer takes no new reading until its result is
// pushed, and a moving one waits on the one-bit-per-cycle divider shared by both divisions
// reset: asynchronous, clears queues, ring valid bits and held state; no clearing pass
`timescale 1ns / 1ps
module encoder_position_speed_tracker_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  epst_pkg::in_item_t              in_item,
    output logic                            empty,
    input  logic                            pop,
    output epst_pkg::out_item_t             out_item,
    input  logic                            wr_en,
    input  logic [epst_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [epst_pkg::CFG_DATA_W-1:0] wr_data
);
    import epst_pkg::*;

    cfg_t             cfg_reg;
    logic             q_empty, deq;
    front_item_t      q_item;
    logic             out_full, out_push;
    out_item_t        out_data;
    out_item_t        oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_AW:0]   oq_cnt_reg;
    logic             oq_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.angle_offset <= '0;
            cfg_reg.pole_pairs   <= 6'd7;
            cfg_reg.stale_ticks  <= 32'd100000;
        end
        else if (wr_en) begin
            case (wr_index)
                REG_ANGLE_OFFSET: cfg_reg.angle_offset <= wr_data[15:0];
                REG_POLE_PAIRS:   cfg_reg.pole_pairs   <= wr_data[5:0];
                REG_STALE_TICKS:  cfg_reg.stale_ticks  <= wr_data[31:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    epst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .deq     (deq),
        .q_empty (q_empty),
        .q_item  (q_item)
    );

    epst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .deq      (deq),
        .cfg      (cfg_reg),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_data)
    );

    // result queue
    assign empty    = oq_cnt_reg == '0;
    assign out_full = oq_cnt_reg == (OQ_AW+1)'(OQ_DEPTH);
    assign oq_pop   = pop && !empty;
    assign out_item = oq_mem[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else begin
            if (out_push)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
            if (out_push && !oq_pop)
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            else if (!out_push && oq_pop)
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            oq_mem[oq_wr_reg] <= out_data;
    end
endmodule

// ----- test/encoder_position_speed_tracker_unit_checker.sv -----
// checker for the encoder tracker: follows register writes, predicts each result, compares
`timescale 1ns / 1ps
module encoder_position_speed_tracker_unit_checker
    import epst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_item_t              in_item,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             out_item,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    localparam int CPT = 1 << CPT_LOG2;

    // register copy
    logic [15:0] offset_q;
    logic [5:0]  pairs_q;
    logic [31:0] stale_q;

    // tracking state
    logic [15:0] prev_raw;
    longint      base;
    longint      hist_pos [RING_DEPTH];
    longint      hist_tick [RING_DEPTH];
    int          hist_spd [RING_DEPTH];
    int          newest;
    int          spd_hold;
    int          acc_hold;
    logic [15:0] mech_hold;

    out_item_t   expected_q [$];

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic int clamp_q16(input longint unsigned m, input bit neg);
        if (neg)
            return (m >= 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(m));
        return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(m);
    endfunction

    function automatic bit too_old(input longint now_t, input longint t);
        return (now_t - t) > longint'({32'd0, stale_q});
    endfunction

    // low 16 bits of floor(speed * age / counts per turn)
    function automatic logic [15:0] angle_advance(input int s, input longint dt);
        longint unsigned sm, dm, a, b, c2, q2, r2;
        logic [15:0] low;
        sm = magnitude(longint'(s));
        dm = magnitude(dt);
        a = sm * (dm >> 24);
        b = sm * (dm & 64'hFF_FFFF);
        c2 = ((a % CPT) << 24) + b;
        q2 = c2 / CPT;
        r2 = c2 % CPT;
        low = q2[15:0];
        if (((s < 0) != (dt < 0)) && sm != 0 && dm != 0)
            low = 16'(16'd0 - low - (r2 != 0 ? 16'd1 : 16'd0));
        return low;
    endfunction

    function automatic out_item_t track_reading(input in_item_t it);
        out_item_t r;
        longint cap, now_t, pos, rem, dp, dt, dv;
        longint unsigned dtm;
        int diff, oldest;
        logic [15:0] e;
        cap = longint'({16'd0, it.capture_tick});
        now_t = longint'({16'd0, it.now_tick});
        if (it.raw_position != prev_raw) begin
            diff = int'(it.raw_position) - int'(prev_raw);
            if (diff > 32767)
                base = (base - 65536 < -(64'sd1 <<< 47)) ? -(64'sd1 <<< 47) : base - 65536;
            else if (diff < -32767)
                base = (base + 65536 > (64'sd1 <<< 47) - 1 - 65535) ?
                       (64'sd1 <<< 47) - 1 - 65535 : base + 65536;
            prev_raw = it.raw_position;
            pos = base + longint'(it.raw_position);
            rem = pos % CPT;
            if (rem < 0)
                rem += CPT;
            mech_hold = 16'(((rem << 16) / CPT) - longint'(offset_q));
            newest = (newest + 1) % RING_DEPTH;
            hist_pos[newest] = pos;
            hist_tick[newest] = cap;
            oldest = (newest + 1) % RING_DEPTH;
            while (oldest != newest && too_old(now_t, hist_tick[oldest]))
                oldest = (oldest + 1) % RING_DEPTH;
            dp = hist_pos[newest] - hist_pos[oldest];
            dt = hist_tick[newest] - hist_tick[oldest];
            // no usable window or no motion
            if (oldest == newest || dp == 0 || dt == 0) begin
                spd_hold = 0;
                acc_hold = 0;
                hist_spd[newest] = 0;
            end
            else begin
                dtm = magnitude(dt);
                spd_hold = clamp_q16((magnitude(dp) << 16) / dtm, (dp < 0) != (dt < 0));
                hist_spd[newest] = spd_hold;
                dv = longint'(spd_hold) - longint'(hist_spd[oldest]);
                acc_hold = clamp_q16(magnitude(dv) / dtm, (dv < 0) != (dt < 0));
            end
        end
        else begin
            pos = base + longint'(it.raw_position);
            if (too_old(now_t, hist_tick[newest])) begin
                spd_hold = 0;
                acc_hold = 0;
            end
        end
        e = 16'(mech_hold + angle_advance(spd_hold, now_t - hist_tick[newest]));
        e = 16'(32'(e) * 32'(pairs_q));
        r.multi_turn_position = pos[47:0];
        r.mech_angle = mech_hold;
        r.elec_angle = e;
        r.speed = spd_hold;
        r.acceleration = acc_hold;
        return r;
    endfunction

    assign pending = expected_q.size();

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            offset_q = 16'd0;
            pairs_q = 6'd7;
            stale_q = 32'd100000;
            prev_raw = 16'd0;
            base = 0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                hist_pos[i] = 0;
                hist_tick[i] = 0;
                hist_spd[i] = 0;
            end
            newest = 0;
            spd_hold = 0;
            acc_hold = 0;
            mech_hold = 16'd0;
            expected_q.delete();
            errors = 0;
            checked = 0;
        end
        else begin
            if (wr_en) begin
                case (wr_index)
                    REG_ANGLE_OFFSET: offset_q = wr_data[15:0];
                    REG_POLE_PAIRS:   pairs_q = wr_data[5:0];
                    REG_STALE_TICKS:  stale_q = wr_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                checked++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $error("result transfer with nothing expected");
                end
                else begin
                    want = expected_q.pop_front();
                    if (out_item.multi_turn_position !== want.multi_turn_position) begin
                        errors++;
                        $error("multi_turn_position expected %0d actual %0d",
                               want.multi_turn_position, out_item.multi_turn_position);
                    end
                    if (out_item.mech_angle !== want.mech_angle) begin
                        errors++;
                        $error("mech_angle expected %0d actual %0d",
                               want.mech_angle, out_item.mech_angle);
                    end
                    if (out_item.elec_angle !== want.elec_angle) begin
                        errors++;
                        $error("elec_angle expected %0d actual %0d",
                               want.elec_angle, out_item.elec_angle);
                    end
                    if (out_item.speed !== want.speed) begin
                        errors++;
                        $error("speed expected %0d actual %0d", want.speed, out_item.speed);
                    end
                    if (out_item.acceleration !== want.acceleration) begin
                        errors++;
                        $error("acceleration expected %0d actual %0d",
                               want.acceleration, out_item.acceleration);
                    end
                end
            end
            if (push && !full)
                expected_q.push_back(track_reading(in_item));
        end
    end

endmodule

// ----- test/encoder_position_speed_tracker_unit_tb.sv -----
// testbench top for the encoder tracker: clock, reset, stimulus, register phases, verdict
`timescale 1ns / 1ps
module encoder_position_speed_tracker_unit_tb;
    import epst_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              in_item;
    logic                  empty;
    logic                  pop;
    out_item_t             out_item;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    int          errors;
    int          pending;
    int          checked;
    int          cycles;
    int          sent;
    bit          gaps_on;
    int          pop_hold;
    logic [15:0] raw_now;
    logic [47:0] tick_now;

    encoder_position_speed_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    encoder_position_speed_tracker_unit_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("encoder_position_speed_tracker_unit_tb NOT OK");
            $finish;
        end
    end

    // result side: pop with random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(0, 17);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic logic [47:0] any_tick();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send(input logic [15:0] raw, input logic [47:0] cap, input logic [47:0] nw);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{raw_position: raw, capture_tick: cap, now_tick: nw};
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    // let every expected result drain before touching a register
    task automatic settle();
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] off, input logic [5:0] pp, input logic [31:0] st);
        settle();
        write_reg(REG_ANGLE_OFFSET, {16'd0, off});
        write_reg(REG_POLE_PAIRS, {26'd0, pp});
        write_reg(REG_STALE_TICKS, st);
    endtask

    // mostly steady motion, with unchanged readings, jumps, noise and odd timing mixed in
    task automatic motion(input int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                raw_now = 16'(int'(raw_now) + $urandom_range(0, 4000) - 2000);
                tick_now = tick_now + 48'($urandom_range(1, 4000));
                send(raw_now, tick_now, tick_now + 48'($urandom_range(0, 500)));
            end
            else if (kind < 75)
                send(raw_now, tick_now, tick_now + 48'($urandom_range(0, 200000)));
            else if (kind < 85) begin
                raw_now = 16'($urandom);
                tick_now = tick_now + 48'($urandom_range(1, 10));
                send(raw_now, tick_now, tick_now);
            end
            else if (kind < 92) begin
                raw_now = 16'($urandom);
                send(raw_now, any_tick(), any_tick());
            end
            else begin
                // capture at or before an earlier one, or in the future
                raw_now = raw_now + 16'($urandom_range(1, 300));
                send(raw_now, tick_now - 48'($urandom_range(0, 1000)),
                     tick_now - 48'($urandom_range(0, 50)));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        in_item <= '0;
        wr_en <= 1'b0;
        wr_index <= REG_ANGLE_OFFSET;
        wr_data <= '0;
        cycles = 0;
        sent = 0;
        pop_hold = 0;
        gaps_on = 1'b1;
        raw_now = 16'd0;
        tick_now = 48'd1000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, wraps, repeats, stale data, zero and reversed time
        send(16'h0000, 48'd0, 48'd0);
        send(16'hFFFF, 48'd10, 48'd10);
        send(16'h0000, 48'd20, 48'd25);
        send(16'h7FFF, 48'd30, 48'd30);
        send(16'hFFFF, 48'd40, 48'd40);
        send(16'h8000, 48'd41, 48'd41);
        send(16'h8000, 48'd41, 48'd500);
        send(16'h8100, 48'd41, 48'd41);
        send(16'h9000, 48'd30, 48'd42);
        send(16'h9000, 48'd30, 48'd200000);
        send(16'h9100, 48'd300000, 48'd300000);
        send(16'h9200, 48'hFFFF_FFFF_FFFF, 48'd300001);
        send(16'h9300, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(16'h9300, 48'd0, 48'hFFFF_FFFF_FFFF);
        send(16'h1234, 48'd1, 48'd0);
        send(16'h1000, 48'd2, 48'd3);
        send(16'h1001, 48'd3, 48'd3);
        send(16'h0FFF, 48'd4, 48'h8000_0000_0000);
        send(16'h5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        send(16'hAAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);

        motion(160);
        set_regs(16'd0, 6'd1, 32'd1);
        motion(150);
        set_regs(16'hFFFF, 6'd32, 32'hFFFF_FFFF);
        motion(150);
        set_regs(16'($urandom), 6'($urandom_range(1, 32)), 32'($urandom_range(1, 400000)));
        motion(150);
        set_regs(16'h1234, 6'd13, 32'd5000);
        motion(130);
        gaps_on = 1'b0;
        motion(140);

        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d readings sent over five register settings, %0d results compared",
                 sent, checked);
        if (errors == 0)
            $display("encoder_position_speed_tracker_unit_tb OK");
        else
            $display("encoder_position_speed_tracker_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/epst_pkg.sv
design/epst_div.sv
design/epst_front.sv
design/epst_back.sv
design/encoder_position_speed_tracker_unit.sv
test/encoder_position_speed_tracker_unit_checker.sv
test/encoder_position_speed_tracker_unit_tb.sv
